// ===== src/pmar_pkg.sv =====
// Package with the shared types, constants and arithmetic helpers of the alpha requantizer.
`default_nettype none
package pmar_pkg;

	localparam int unsigned TABLE_DEPTH = 65536;
	localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
	localparam int unsigned NUM_CH = 3;
	localparam int unsigned LAST_STAGE = 20;

	localparam logic OP_CONVERT = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_CLEAR = 8'd0;
	localparam logic [7:0] CHAN_MAX = 8'd255;

	// Working state of one pixel as it moves down the pipeline.
	typedef struct packed {
		logic                     is_opaque;
		logic                     is_clear;
		logic                     tbl_mode;
		logic [7:0]               a;
		logic [NUM_CH-1:0][7:0]   p;
		logic [NUM_CH-1:0]        sat;
		logic [NUM_CH-1:0][7:0]   tbl;
		logic [NUM_CH-1:0][15:0]  w;
		logic [NUM_CH-1:0][7:0]   quo;
	} pix_t;

	// Rounded division by 255 of a value up to 65025: floor((w+127)/255).
	function automatic logic [7:0] div255_rnd(input logic [15:0] w);
		logic [16:0] t;
		logic [16:0] u;
		t = {1'b0, w} + 17'd127;
		u = t + (t >> 8) + 17'd1;
		return u[15:8];
	endfunction

	// n*255 + a/2, the rounded dividend of an un-premultiply.
	function automatic logic [15:0] unpremul_num(input logic [7:0] n, input logic [7:0] a);
		return {n, 8'd0} - {8'd0, n} + {9'd0, a[7:1]};
	endfunction

endpackage
`default_nettype wire

// ===== src/premultiplied_alpha_requantize.sv =====
// Premultiplied alpha requantizer: pipelined computed path and table lookup path.
// A pixel item is captured in register stage 0 when it is accepted and moves through
// register stages 0 to 20 before its result is offered on the master side.
// Throughput: one item per cycle; the whole pipeline stalls only while its last
// stage holds a result that the master side does not take.
// Table write items are stored at acceptance and cause no result.
// Reset clears the mode register and the pipeline valid bits; the table is not cleared.
`default_nettype none
module premultiplied_alpha_requantize (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,      // use_measured_table
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24],
	// entry_index[47:32], entry_value[55:48]
	input  wire logic [55:0] s_axis_tdata,
	input  wire logic        s_axis_tuser,   // op
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
	output logic [31:0]      m_axis_tdata
);
	import pmar_pkg::*;

	// Stage map of the computed path:
	//   0      dividend p*255 + a/2 for each channel, table read issued
	//   1..8   first division by alpha, one quotient bit per stage
	//   9      clamp to 255, multiply by alpha
	//   10     divide by 255 with rounding, multiply by alpha again
	//   11     divide by 255, build the second dividend r*255 + a/2
	//   12..19 second division by alpha
	//   20     select opaque, clear, table or computed value (output register)

	logic                 use_tbl_q;
	logic                 adv;
	logic                 take;
	logic                 wr_en;
	logic                 rd_en;
	logic [7:0]           in_a;
	logic [2:0][7:0]      in_p;
	logic [2:0][ADDR_W-1:0] rd_addr;
	logic [2:0][7:0]      rdata_q;
	logic [ADDR_W-1:0]    wr_addr;
	logic [7:0]           wr_val;
	pix_t                 first_pix;
	pix_t                 pipe_s [0:LAST_STAGE];
	logic                 vld_s  [0:LAST_STAGE];

	// Two copies of the table: one is read at the red and the green address, the
	// other at the blue address, so that all three lookups of a pixel happen in
	// the same cycle; every write goes to both.
	logic [7:0] mem_rg [0:TABLE_DEPTH-1];
	logic [7:0] mem_b [0:TABLE_DEPTH-1];

	function automatic pix_t pipe_step(input int unsigned k, input pix_t x,
			input logic [2:0][7:0] rd);
		pix_t        y;
		logic [15:0] d;
		logic [2:0]  b;
		logic [7:0]  v;
		y = x;
		b = 3'd0;
		for (int c = 0; c < NUM_CH; c++) begin
			if (k == 1) begin
				y.tbl[c] = rd[c];
			end
			if ((k >= 1 && k <= 8) || (k >= 12 && k <= 19)) begin
				b = (k <= 8) ? 3'(8 - k) : 3'(19 - k);
				d = {8'd0, x.a} << b;
				if (x.w[c] >= d) begin
					y.w[c] = x.w[c] - d;
					y.quo[c] = x.quo[c] | (8'd1 << b);
				end
			end else if (k == 9) begin
				v = x.sat[c] ? CHAN_MAX : x.quo[c];
				y.w[c] = {8'd0, v} * {8'd0, x.a};
			end else if (k == 10) begin
				v = div255_rnd(x.w[c]);
				y.w[c] = {8'd0, v} * {8'd0, x.a};
			end else if (k == 11) begin
				v = div255_rnd(x.w[c]);
				y.w[c] = unpremul_num(v, x.a);
				y.quo[c] = 8'd0;
			end else if (k == LAST_STAGE) begin
				if (x.is_clear) begin
					y.quo[c] = 8'd0;
				end else if (x.is_opaque) begin
					y.quo[c] = x.p[c];
				end else if (x.tbl_mode) begin
					y.quo[c] = x.tbl[c];
				end else begin
					y.quo[c] = x.quo[c];
				end
			end
		end
		return y;
	endfunction

	// The pipeline moves as one; it holds only while the result waits.
	assign adv = !vld_s[LAST_STAGE] || m_axis_tready;
	assign s_axis_tready = adv;
	assign take = s_axis_tvalid && adv;
	assign wr_en = take && (s_axis_tuser == OP_WRITE);
	assign rd_en = take && (s_axis_tuser == OP_CONVERT);

	assign in_a = s_axis_tdata[31:24];
	assign in_p[0] = s_axis_tdata[7:0];
	assign in_p[1] = s_axis_tdata[15:8];
	assign in_p[2] = s_axis_tdata[23:16];
	assign wr_addr = s_axis_tdata[47:32];
	assign wr_val = s_axis_tdata[55:48];

	always_comb begin
		first_pix = '0;
		first_pix.a = in_a;
		first_pix.p = in_p;
		first_pix.is_opaque = (in_a == ALPHA_OPAQUE);
		first_pix.is_clear = (in_a == ALPHA_CLEAR);
		first_pix.tbl_mode = use_tbl_q;
		for (int c = 0; c < NUM_CH; c++) begin
			// A channel at or above alpha un-premultiplies to 255 or more.
			first_pix.sat[c] = (in_p[c] >= in_a);
			first_pix.w[c] = unpremul_num(in_p[c], in_a);
			rd_addr[c] = {in_a, (in_p[c] < in_a) ? in_p[c] : in_a};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_rg[wr_addr] <= wr_val;
			mem_b[wr_addr] <= wr_val;
		end
		if (rd_en) begin
			rdata_q[0] <= mem_rg[rd_addr[0]];
			rdata_q[1] <= mem_rg[rd_addr[1]];
			rdata_q[2] <= mem_b[rd_addr[2]];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[0] <= first_pix;
			for (int k = 1; k <= LAST_STAGE; k++) begin
				pipe_s[k] <= pipe_step(k, pipe_s[k-1], rdata_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_tbl_q <= 1'b0;
			for (int k = 0; k <= LAST_STAGE; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				use_tbl_q <= cfg_wdata;
			end
			if (adv) begin
				vld_s[0] <= rd_en;
				for (int k = 1; k <= LAST_STAGE; k++) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign m_axis_tvalid = vld_s[LAST_STAGE];
	assign m_axis_tdata = {pipe_s[LAST_STAGE].a, pipe_s[LAST_STAGE].quo[2],
		pipe_s[LAST_STAGE].quo[1], pipe_s[LAST_STAGE].quo[0]};

endmodule
`default_nettype wire
